@@ rtl/png_scanline_unfilter_gray8_assert.svh @@
// Assertion helpers for the scanline unfilter RTL.
`ifndef PNG_SCANLINE_UNFILTER_GRAY8_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_GRAY8_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/png_unf_pkg.sv @@
package png_unf_pkg;

    // Column offset carried with each word; covers the largest line buffer.
    localparam int XW = 16;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    // Largest legal filter type.
    localparam logic [7:0] FILT_MAX = 8'd4;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ROW_WIDTH    = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // One classified word passed from the front to the back.
    typedef struct packed {
        logic [7:0]    raw;
        filt_t         filt;
        logic [XW-1:0] x;
        logic          first;
        logic          up_zero;
        logic          row_end;
        logic          image_end;
        logic          bad;
    } work_t;

    function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b,
                                              logic [7:0] c);
        logic signed [10:0] p;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        da = p - $signed({3'b000, a});
        db = p - $signed({3'b000, b});
        dc = p - $signed({3'b000, c});
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    function automatic logic [7:0] predict(filt_t filt, logic [7:0] a,
                                           logic [7:0] b, logic [7:0] c);
        logic [8:0] sum;
        logic [7:0] pred;
        sum = {1'b0, a} + {1'b0, b};
        case (filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum[8:1];
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'd0;
        endcase
        return pred;
    endfunction

endpackage

@@ rtl/png_unf_front.sv @@
module png_unf_front
    import png_unf_pkg::*;
#(
    parameter  int MAX_WIDTH = 4096,
    localparam int CW        = $clog2(MAX_WIDTH + 1),
    localparam int CMPW      = (CW > 13) ? CW : 13
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_raw,
    input  logic        in_sof,
    input  logic [12:0] row_width,
    input  logic [15:0] image_height,
    input  logic        q_full,
    output logic        q_push,
    output work_t       q_din
);

    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    filt_t         filt_reg, filt_next;
    logic          halted_reg, halted_next;

    logic          accept;
    logic          eff_halted;
    logic [CW-1:0] eff_col;
    logic [15:0]   eff_row;
    logic          rend, iend;
    logic [16:0]   row_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Start of image overrides position and wakes the front.
    assign eff_halted = in_sof ? 1'b0 : halted_reg;
    assign eff_col    = in_sof ? '0 : col_reg;
    assign eff_row    = in_sof ? 16'd0 : row_reg;

    // Row end against the clamped width; column never passes MAX_WIDTH.
    assign rend    = (CMPW'(eff_col) >= CMPW'(row_width))
                   || (eff_col == CW'(MAX_WIDTH));
    assign row_inc = {1'b0, eff_row} + 17'd1;
    assign iend    = rend && (row_inc >= {1'b0, image_height});

    // Classify the word and advance the row position.
    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        filt_next   = filt_reg;
        halted_next = halted_reg;
        q_push      = 1'b0;
        q_din       = '0;
        if (accept) begin
            col_next    = eff_col;
            row_next    = eff_row;
            halted_next = eff_halted;
            if (!eff_halted) begin
                if (eff_col == '0) begin
                    if (in_raw > FILT_MAX) begin
                        q_push      = 1'b1;
                        q_din.bad   = 1'b1;
                        halted_next = 1'b1;
                    end else begin
                        filt_next = filt_t'(in_raw[2:0]);
                        col_next  = CW'(1);
                    end
                end else begin
                    q_push          = 1'b1;
                    q_din.raw       = in_raw;
                    q_din.filt      = filt_reg;
                    q_din.x         = XW'(eff_col - CW'(1));
                    q_din.first     = (eff_col == CW'(1));
                    q_din.up_zero   = (eff_row == 16'd0);
                    q_din.row_end   = rend;
                    q_din.image_end = iend;
                    if (rend) begin
                        col_next = '0;
                        if (iend) begin
                            halted_next = 1'b1;
                        end else begin
                            row_next = row_inc[15:0];
                        end
                    end else begin
                        col_next = eff_col + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= 16'd0;
            filt_reg   <= FILT_NONE;
            halted_reg <= 1'b1;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            filt_reg   <= filt_next;
            halted_reg <= halted_next;
        end
    end

endmodule

@@ rtl/png_unf_queue.sv @@
module png_unf_queue
    import png_unf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  work_t        din,
    input  logic         pop,
    output work_t        dout,
    output logic         full,
    output logic         empty,
    output logic [QAW:0] count
);

    work_t          slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign dout  = slot_reg[rd_ptr_reg];

    // Store a word at the tail.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QAW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QAW+1)'(1);
            end
        end
    end

endmodule

@@ rtl/png_unf_back.sv @@
module png_unf_back
    import png_unf_pkg::*;
#(
    parameter  int MAX_WIDTH = 4096,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  work_t      q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_pixel,
    output logic       out_row_end,
    output logic       out_image_end,
    output logic       out_bad
);

    logic [7:0] line_mem [MAX_WIDTH];

    work_t      r_reg;
    logic       r_vld_reg;
    logic [7:0] rd_reg;
    logic       byp_reg;
    logic [7:0] byp_val_reg;
    logic [7:0] left_reg;
    logic [7:0] upleft_reg;

    logic       o_vld_reg;
    logic [7:0] o_pixel_reg;
    logic       o_row_end_reg;
    logic       o_image_end_reg;
    logic       o_bad_reg;

    logic       r_adv;
    logic       r_fire;
    logic [7:0] up, a_val, c_val, val;

    assign r_adv  = !o_vld_reg || out_ready;
    assign r_fire = r_vld_reg && r_adv;
    assign q_pop  = !q_empty && (!r_vld_reg || r_adv);

    // Rebuild the pixel from its neighbors; forward a write the read missed.
    assign up    = r_reg.up_zero ? 8'd0 : (byp_reg ? byp_val_reg : rd_reg);
    assign a_val = r_reg.first ? 8'd0 : left_reg;
    assign c_val = r_reg.first ? 8'd0 : upleft_reg;
    assign val   = r_reg.raw + predict(r_reg.filt, a_val, up, c_val);

    // Line buffer: read on pop, write when the pixel leaves the stage.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_reg <= line_mem[q_head.x[AW-1:0]];
        end
        if (r_fire && !r_reg.bad) begin
            line_mem[r_reg.x[AW-1:0]] <= val;
        end
    end

    // Load the reconstruction stage.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            r_reg       <= q_head;
            byp_reg     <= r_fire && !r_reg.bad && (r_reg.x == q_head.x);
            byp_val_reg <= val;
        end
    end

    // Hold neighbors and stage occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_vld_reg  <= 1'b0;
            left_reg   <= 8'd0;
            upleft_reg <= 8'd0;
        end else begin
            if (q_pop) begin
                r_vld_reg <= 1'b1;
            end else if (r_fire) begin
                r_vld_reg <= 1'b0;
            end
            if (r_fire && !r_reg.bad) begin
                left_reg   <= val;
                upleft_reg <= up;
            end
        end
    end

    // Output register; the stage advances only while it is empty or its word is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (r_adv) begin
            o_vld_reg <= r_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_fire) begin
            o_pixel_reg     <= r_reg.bad ? 8'd0 : val;
            o_row_end_reg   <= r_reg.row_end;
            o_image_end_reg <= r_reg.image_end;
            o_bad_reg       <= r_reg.bad;
        end
    end

    assign out_valid     = o_vld_reg;
    assign out_pixel     = o_pixel_reg;
    assign out_row_end   = o_row_end_reg;
    assign out_image_end = o_image_end_reg;
    assign out_bad       = o_bad_reg;

endmodule

@@ rtl/png_scanline_unfilter_gray8.sv @@
// Channel   | Direction | Signals                         | Word contents
// s_        | in        | s_tvalid s_tready s_tdata s_tuser | raw byte, start of image
// m_        | out       | m_tvalid m_tready m_tdata m_tlast m_tuser | pixel, row/image end, error
// APB       | in/out    | psel penable pwrite paddr pwdata prdata pready | row_width, image_height
//
// One input word per cycle sustained while m_tready is high; the Sub/Average/Paeth
// left-neighbor add is combinational in the back stage, and the line buffer has one
// read and one write port. A result passes the queue slot, the reconstruction register
// and the output register. Synchronous active-low reset; the line buffer is not
// cleared and needs no clearing pass. s_tready drops only while the two-word queue is full.
`include "png_scanline_unfilter_gray8_assert.svh"

module png_scanline_unfilter_gray8
    import png_unf_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] raw_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // s_tuser: [0] start_of_image
    input  logic        s_tuser,
    // m_tdata: [7:0] pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // m_tuser: [0] image_end, [1] bad_filter
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0]  row_width_reg;
    logic [15:0]  image_height_reg;

    logic         q_full, q_empty, q_push, q_pop;
    logic [QAW:0] q_count;
    work_t        q_din, q_head;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= 13'd752;
            image_height_reg <= 16'd480;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_ROW_WIDTH) begin
                row_width_reg <= pwdata[12:0];
            end else begin
                image_height_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? {16'd0, image_height_reg}
                                                   : {19'd0, row_width_reg};

    png_unf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_raw       (s_tdata),
        .in_sof       (s_tuser),
        .row_width    (row_width_reg),
        .image_height (image_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_din        (q_din)
    );

    png_unf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_head),
        .full    (q_full),
        .empty   (q_empty),
        .count   (q_count)
    );

    png_unf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_pixel     (m_tdata),
        .out_row_end   (m_tlast),
        .out_image_end (m_tuser[0]),
        .out_bad       (m_tuser[1])
    );

    // Error words carry no pixel and no row or image end.
    `PSU_ASSERT_NOW(a_bad_clean, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata == 8'd0 && !m_tlast && !m_tuser[0], "error word carries data")
    // The last pixel of an image also closes its row.
    `PSU_ASSERT_NOW(a_image_end_row, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast, "image end without row end")
    // The queue never holds more than its depth.
    `PSU_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1, q_count <= (QAW+1)'(QDEPTH), "queue overflow")
    // A full queue that is not drained keeps the input stalled.
    `PSU_ASSERT_NEXT(a_full_stall, aclk, aresetn, q_full && !q_pop, !s_tready, "input taken into full queue")

endmodule

@@ test/png_scanline_unfilter_gray8_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels and the register port, rebuilds each pixel of the
// gray8 scanline stream on its own and compares every result word in order.
module png_scanline_unfilter_gray8_checker
    import png_unf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam int LINE_MAX = 4096;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];

    // Shadow of the block: previous row, neighbors, position and settings
    logic [7:0]  line_buf [0:LINE_MAX-1];
    logic [7:0]  left_pix;
    logic [7:0]  upleft_pix;
    int unsigned col;
    logic [15:0] row_num;
    filt_t       row_filter;
    bit          stopped;
    logic [12:0] width_reg;
    logic [15:0] height_reg;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [7:0] paeth_choose(logic [7:0] a, logic [7:0] b,
                                                logic [7:0] c);
        int est;
        int dist_a;
        int dist_b;
        int dist_c;
        est    = int'(a) + int'(b) - int'(c);
        dist_a = est - int'(a);
        dist_b = est - int'(b);
        dist_c = est - int'(c);
        if (dist_a < 0) dist_a = -dist_a;
        if (dist_b < 0) dist_b = -dist_b;
        if (dist_c < 0) dist_c = -dist_c;
        if (dist_a <= dist_b && dist_a <= dist_c) return a;
        if (dist_b <= dist_c) return b;
        return c;
    endfunction

    // Rebuild one accepted byte and queue the result word it causes, if any
    task automatic reconstruct_byte(input logic [7:0] raw, input logic sof);
        int          w;
        int          h;
        int          x;
        logic [7:0]  up;
        logic [7:0]  pred;
        logic [7:0]  val;
        logic [8:0]  avg_sum;
        bit          rend;
        bit          iend;
        pixel_word_t res;
        w = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        if (sof) begin
            stopped = 0;
            row_num = '0;
            col     = 0;
        end
        if (stopped) return;

        // Filter type byte: either select the filter or flag the error and stop
        if (col == 0) begin
            if (raw > 8'(FILT_PAETH)) begin
                stopped = 1;
                res = '{pixel: 8'd0, row_end: 1'b0, image_end: 1'b0, bad_filter: 1'b1};
                expected_pixels.push_back(res);
            end else begin
                row_filter = filt_t'(raw[2:0]);
                left_pix   = 8'd0;
                upleft_pix = 8'd0;
                col        = 1;
            end
            return;
        end

        x  = int'(col) - 1;
        up = (row_num != 0) ? line_buf[x] : 8'd0;
        case (row_filter)
            FILT_SUB:   pred = left_pix;
            FILT_UP:    pred = up;
            FILT_AVG: begin
                avg_sum = {1'b0, left_pix} + {1'b0, up};
                pred    = avg_sum[8:1];
            end
            FILT_PAETH: pred = paeth_choose(left_pix, up, upleft_pix);
            default:    pred = 8'd0;
        endcase
        val = raw + pred;

        line_buf[x] = val;
        upleft_pix  = up;
        left_pix    = val;

        // Advance the position; the last pixel of the last row stops the block
        rend = (int'(col) >= w);
        iend = rend && (int'(row_num) + 1 >= h);
        if (rend) begin
            col = 0;
            if (iend) stopped = 1;
            else row_num = row_num + 16'd1;
        end else begin
            col = col + 1;
        end

        res = '{pixel: val, row_end: rend, image_end: iend, bad_filter: 1'b0};
        expected_pixels.push_back(res);
    endtask

    // Compare one result word against the oldest expectation
    task automatic check_result();
        pixel_word_t exp_word;
        if (expected_pixels.size() == 0) begin
            $error("result word with nothing expected: pixel %0d", m_tdata);
            fail_count++;
            return;
        end
        exp_word = expected_pixels.pop_front();
        if (m_tdata !== exp_word.pixel) begin
            $error("pixel: expected %0d, got %0d", exp_word.pixel, m_tdata);
            fail_count++;
        end
        if (m_tlast !== exp_word.row_end) begin
            $error("row_end: expected %0b, got %0b", exp_word.row_end, m_tlast);
            fail_count++;
        end
        if (m_tuser[0] !== exp_word.image_end) begin
            $error("image_end: expected %0b, got %0b", exp_word.image_end, m_tuser[0]);
            fail_count++;
        end
        if (m_tuser[1] !== exp_word.bad_filter) begin
            $error("bad_filter: expected %0b, got %0b", exp_word.bad_filter, m_tuser[1]);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_pixels.delete();
            left_pix   = 8'd0;
            upleft_pix = 8'd0;
            col        = 0;
            row_num    = '0;
            row_filter = FILT_NONE;
            stopped    = 1;
            width_reg  = 13'd752;
            height_reg = 16'd480;
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_ROW_WIDTH) width_reg = pwdata[12:0];
                else height_reg = pwdata[15:0];
            end
            if (s_tvalid && s_tready) reconstruct_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) check_result();
        end
        pending = expected_pixels.size();
    end

endmodule

@@ test/png_scanline_unfilter_gray8_tb.sv @@
`timescale 1ns / 100ps

module png_scanline_unfilter_gray8_tb
    import png_unf_pkg::*;
();

    localparam int RUN_LIMIT       = 600000;
    localparam int LONG_HOLD       = 300;
    localparam int ITEMS_PER_PHASE = 138;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TRUNC_PCT       = 3;
    localparam int BAD_PCT         = 6;
    localparam int HOLD_PHASE      = 4;
    localparam int NUM_PHASES      = 12;

    typedef enum int {
        IDLE_NONE     = 0,
        IDLE_SENDER   = 1,
        IDLE_RECEIVER = 2,
        IDLE_BOTH     = 3
    } idle_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] raw_byte
    logic        s_tuser;     // [0] start_of_image
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [7:0] pixel
    logic        m_tlast;
    logic [1:0]  m_tuser;     // [0] image_end, [1] bad_filter
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          cycle_count;
    int          phase_items;
    int          width_eff;
    int          height_eff;
    int          hold_asks;
    int          hold_served;
    int          hold_cnt;
    idle_mode_t  idle_mode;
    int          phase_width  [0:NUM_PHASES-1];
    int          phase_height [0:NUM_PHASES-1];

    png_scanline_unfilter_gray8 uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    png_scanline_unfilter_gray8_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 aclk = ~aclk;

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: serve a long hold-off when asked, else stall per idle mode
    always @(negedge aclk) begin
        if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_cnt    = LONG_HOLD;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: m_tready <= ($urandom_range(0, 99) >= 71);
                IDLE_BOTH:     m_tready <= ($urandom_range(0, 99) >= 10);
                default:       m_tready <= 1'b1;
            endcase
        end
    end

    // Offer one word, idling first per the mode; return at the next falling edge
    task automatic send_word(input logic sof, input logic [7:0] b, input bit counted);
        while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 71) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 10)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (counted) phase_items++;
    endtask

    task automatic write_reg(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Drop valid, wait for every expected word, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write both registers with junk above the field, track the values in effect
    task automatic configure(input int w, input int h);
        logic [31:0] reg_val;
        wait_drained();
        reg_val = $urandom;
        reg_val[12:0] = w[12:0];
        write_reg(REG_ROW_WIDTH, reg_val);
        reg_val = $urandom;
        reg_val[15:0] = h[15:0];
        write_reg(REG_IMAGE_HEIGHT, reg_val);
        width_eff  = (w == 0) ? 1 : ((w > 4096) ? 4096 : w);
        height_eff = (h == 0) ? 1 : h;
    endtask

    function automatic logic [7:0] pixel_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 8'h00;
        if (roll < 30) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Stream well-formed images with random content; some rows break off early
    // and restart, some carry a bad filter type
    task automatic run_images(input int budget, input int trunc_pct, input int bad_pct);
        int         first_item;
        int         r;
        int         c;
        logic [7:0] filt;
        bit         cut_short;
        bit         halted_now;
        first_item = phase_items;
        while (phase_items - first_item < budget) begin
            cut_short  = 0;
            halted_now = 0;
            for (r = 0; r < height_eff && !cut_short && !halted_now; r++) begin
                if (r > 0 && phase_items - first_item >= budget) begin
                    cut_short = 1;
                end else begin
                    if ($urandom_range(0, 99) < bad_pct)
                        filt = 8'($urandom_range(5, 255));
                    else
                        filt = 8'($urandom_range(0, 4));
                    send_word(r == 0, filt, 1);
                    if (filt > 8'(FILT_PAETH)) halted_now = 1;
                    for (c = 0; c < width_eff && !cut_short && !halted_now; c++) begin
                        if (c > 0 && $urandom_range(0, 99) < trunc_pct) cut_short = 1;
                        else send_word(1'b0, pixel_byte(), 1);
                    end
                end
            end
            // Feed a stray word or two to a halted block; it must drop them
            if (!cut_short && $urandom_range(0, 3) == 0) begin
                send_word(1'b0, pixel_byte(), 0);
                if ($urandom_range(0, 1) == 1) send_word(1'b0, pixel_byte(), 0);
            end
        end
    endtask

    initial begin
        int p;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 3'd0;
        pwdata      = 32'd0;
        cycle_count = 0;
        phase_items = 0;
        hold_asks   = 0;
        hold_served = 0;
        hold_cnt    = 0;
        idle_mode   = IDLE_NONE;
        phase_width  = '{3, 1, 0, 5, 16, 7, 4096, 8191, 2, 12, 33, 3};
        phase_height = '{4, 1, 0, 3, 2, 65535, 5, 1, 7, 3, 2, 9};

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: 3 pixels by 4 rows, every filter, halts, restarts, errors
        configure(phase_width[0], phase_height[0]);
        send_word(1'b0, 8'hFF, 1);
        send_word(1'b1, 8'(FILT_NONE), 1);
        send_word(1'b0, 8'd255, 1);
        send_word(1'b0, 8'd0, 1);
        send_word(1'b0, 8'd200, 1);
        send_word(1'b0, 8'(FILT_SUB), 1);
        send_word(1'b0, 8'd255, 1);
        send_word(1'b0, 8'd1, 1);
        send_word(1'b0, 8'd128, 1);
        send_word(1'b0, 8'(FILT_UP), 1);
        send_word(1'b0, 8'd1, 1);
        send_word(1'b0, 8'd255, 1);
        send_word(1'b0, 8'd0, 1);
        send_word(1'b0, 8'(FILT_AVG), 1);
        send_word(1'b0, 8'd255, 1);
        send_word(1'b0, 8'd255, 1);
        send_word(1'b0, 8'd3, 1);
        send_word(1'b0, 8'd7, 1);
        send_word(1'b1, 8'(FILT_PAETH), 1);
        send_word(1'b0, 8'd10, 1);
        send_word(1'b0, 8'd250, 1);
        send_word(1'b1, 8'(FILT_PAETH), 1);
        send_word(1'b0, 8'd10, 1);
        send_word(1'b0, 8'd250, 1);
        send_word(1'b0, 8'd3, 1);
        send_word(1'b0, 8'(FILT_PAETH), 1);
        send_word(1'b0, 8'd255, 1);
        send_word(1'b0, 8'd0, 1);
        send_word(1'b0, 8'd128, 1);
        send_word(1'b0, 8'd5, 1);
        send_word(1'b1, 8'd255, 1);

        // Random phases over several sizes and idle patterns
        for (p = 1; p < NUM_PHASES; p++) begin
            configure(phase_width[p], phase_height[p]);
            idle_mode = idle_mode_t'(p % 4);
            if (p == HOLD_PHASE) hold_asks = hold_asks + 1;
            run_images(ITEMS_PER_PHASE, TRUNC_PCT, BAD_PCT);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
